/* sv/ngls_pkg.sv */
// Package for the nearest grid lights selection block.
// Holds the grid constants, the beat and candidate types and a field helper.
// No dependencies; every other file imports it.
package ngls_pkg;

    localparam int GRID_SIDE     = 8;
    localparam int NEAREST_COUNT = 9;
    localparam int FRAC_BITS     = 8;
    localparam int IDX_W         = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int COORD_W       = 16;
    localparam int MAG_W         = COORD_W + 1;
    localparam int SQ_W          = 2 * MAG_W;
    localparam int DIST_W        = 32;
    localparam int POS_OUT_W     = 3;
    localparam int RANK_W        = 4;

    typedef struct packed {
        logic signed [COORD_W-1:0] query_x;
        logic signed [COORD_W-1:0] query_y;
        logic signed [COORD_W-1:0] query_z;
    } query_t;

    typedef struct packed {
        logic [POS_OUT_W-1:0] light_row;
        logic [POS_OUT_W-1:0] light_col;
        logic [DIST_W-1:0]    dist_squared;
        logic [RANK_W-1:0]    rank;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DIST_W-1:0] dist_sq;
    } cand_t;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DIST_W-1:0] dist_sq;
    } entry_t;

    function automatic logic [POS_OUT_W-1:0] out_pos(input logic [IDX_W-1:0] v);
        logic [IDX_W+POS_OUT_W-1:0] w;
        w = {{POS_OUT_W{1'b0}}, v};
        return w[POS_OUT_W-1:0];
    endfunction

endpackage

/* sv/ngls_dist.sv */
// Candidate generator and squared distance pipeline.
// Walks the grid in row-major order, one light per cycle while enabled, and emits candidates.
// Depends on ngls_pkg.
module ngls_dist
    import ngls_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   query_valid,
    output logic   query_ready,
    input  query_t query,
    output cand_t  cand
);

    logic                      busy_reg, busy_next;
    logic [IDX_W-1:0]          row_reg, col_reg;
    logic signed [COORD_W-1:0] qx_reg, qy_reg, qz_reg;
    logic                      gen_last;
    logic                      take;

    logic                      s1_valid_reg, s1_first_reg, s1_last_reg;
    logic [IDX_W-1:0]          s1_row_reg, s1_col_reg;
    logic [MAG_W-1:0]          s1_mx_reg, s1_my_reg, s1_mz_reg;

    logic                      s2_valid_reg, s2_first_reg, s2_last_reg;
    logic [IDX_W-1:0]          s2_row_reg, s2_col_reg;
    logic [SQ_W-1:0]           s2_sx_reg, s2_sy_reg, s2_sz_reg;

    cand_t                     cand_reg;

    logic signed [MAG_W-1:0]   dx, dy, dz;
    logic [MAG_W-1:0]          mx, my, mz;
    logic [SQ_W:0]             sum;

    assign gen_last    = (row_reg == IDX_W'(GRID_SIDE - 1)) && (col_reg == IDX_W'(GRID_SIDE - 1));
    assign query_ready = en && (!busy_reg || gen_last);
    assign take        = query_valid && query_ready;

    always_comb
    begin
        busy_next = busy_reg;
        if (take)
        begin
            busy_next = 1'b1;
        end
        else if (en && gen_last)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            qx_reg  <= query.query_x;
            qy_reg  <= query.query_y;
            qz_reg  <= query.query_z;
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (en && busy_reg)
        begin
            if (col_reg == IDX_W'(GRID_SIDE - 1))
            begin
                col_reg <= '0;
                row_reg <= row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    assign dx = MAG_W'(qx_reg) - MAG_W'({row_reg, {FRAC_BITS{1'b0}}});
    assign dy = MAG_W'(qy_reg);
    assign dz = MAG_W'(qz_reg) - MAG_W'({col_reg, {FRAC_BITS{1'b0}}});
    assign mx = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    assign my = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    assign mz = dz[MAG_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
    assign sum = (SQ_W+1)'(s2_sx_reg) + (SQ_W+1)'(s2_sy_reg) + (SQ_W+1)'(s2_sz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            cand_reg     <= '0;
        end
        else if (en)
        begin
            s1_valid_reg     <= busy_reg;
            s2_valid_reg     <= s1_valid_reg;
            cand_reg.valid   <= s2_valid_reg;
            cand_reg.first   <= s2_first_reg;
            cand_reg.last    <= s2_last_reg;
            cand_reg.row     <= s2_row_reg;
            cand_reg.col     <= s2_col_reg;
            cand_reg.dist_sq <= (|sum[SQ_W:DIST_W]) ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_first_reg   <= (row_reg == '0) && (col_reg == '0);
            s1_last_reg    <= gen_last;
            s1_row_reg     <= row_reg;
            s1_col_reg     <= col_reg;
            s1_mx_reg      <= mx;
            s1_my_reg      <= my;
            s1_mz_reg      <= mz;

            s2_first_reg   <= s1_first_reg;
            s2_last_reg    <= s1_last_reg;
            s2_row_reg     <= s1_row_reg;
            s2_col_reg     <= s1_col_reg;
            s2_sx_reg      <= s1_mx_reg * s1_mx_reg;
            s2_sy_reg      <= s1_my_reg * s1_my_reg;
            s2_sz_reg      <= s1_mz_reg * s1_mz_reg;
        end
    end

    assign cand = cand_reg;

endmodule

/* sv/ngls_cell.sv */
// One insertion cell of the sorted nearest-light chain.
// Holds one entry and shifts toward higher ranks when a nearer candidate arrives.
// Depends on ngls_pkg.
module ngls_cell
    import ngls_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  cand_t  cand,
    input  entry_t prev_pass,
    input  logic   prev_lt,
    output entry_t pass,
    output logic   lt,
    output entry_t held
);

    entry_t entry_reg;
    logic   own_valid;

    assign own_valid = entry_reg.valid && !cand.first;
    assign lt        = cand.valid && (!own_valid || (cand.dist_sq < entry_reg.dist_sq));
    assign pass      = '{valid: own_valid, row: entry_reg.row, col: entry_reg.col,
                         dist_sq: entry_reg.dist_sq};
    assign held      = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (en && lt)
        begin
            if (prev_lt)
            begin
                entry_reg.valid   <= prev_pass.valid;
                entry_reg.row     <= prev_pass.row;
                entry_reg.col     <= prev_pass.col;
                entry_reg.dist_sq <= prev_pass.dist_sq;
            end
            else
            begin
                entry_reg.valid   <= 1'b1;
                entry_reg.row     <= cand.row;
                entry_reg.col     <= cand.col;
                entry_reg.dist_sq <= cand.dist_sq;
            end
        end
    end

endmodule

/* sv/ngls_drain.sv */
// Result buffer that takes a finished nearest list and sends it out one beat at a time.
// Loads all entries at once and shifts toward the head on each accepted beat.
// Depends on ngls_pkg.
module ngls_drain
    import ngls_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  entry_t  held [NEAREST_COUNT],
    output logic    busy,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    entry_t            buf_reg [NEAREST_COUNT];
    logic [RANK_W-1:0] rank_reg;
    logic              shift;
    entry_t            next_entry [NEAREST_COUNT];

    assign busy         = buf_reg[0].valid;
    assign result_valid = buf_reg[0].valid;
    assign shift        = result_valid && result_ready;

    genvar i;
    generate
        for (i = 0; i < NEAREST_COUNT; i++)
        begin : g_slot
            if (i + 1 < NEAREST_COUNT)
            begin : g_mid
                assign next_entry[i] = buf_reg[i+1];
            end
            else
            begin : g_end
                assign next_entry[i] = '0;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    buf_reg[i] <= '0;
                end
                else if (load)
                begin
                    buf_reg[i] <= held[i];
                end
                else if (shift)
                begin
                    buf_reg[i] <= next_entry[i];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
        end
        else if (load)
        begin
            rank_reg <= '0;
        end
        else if (shift)
        begin
            rank_reg <= rank_reg + 1'b1;
        end
    end

    assign result.light_row    = out_pos(buf_reg[0].row);
    assign result.light_col    = out_pos(buf_reg[0].col);
    assign result.dist_squared = buf_reg[0].dist_sq;
    assign result.rank         = rank_reg;
    assign result.last         = !next_entry[0].valid;

endmodule

/* sv/nearest_grid_lights_select_core.sv */
// A new query can be accepted while the last grid light of the previous one is generated; grid lights
// enter the insertion cell chain one per cycle while the core is enabled, and result beats drain
// one per cycle while result_ready is high, in the shadow of the next query.
// Reset clears the control flags, rank counter, candidate and list registers; no clearing pass
// is needed.
module nearest_grid_lights_select_core
    import ngls_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    query_valid,
    output logic    query_ready,
    input  query_t  query,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    cand_t  cand;
    logic   en;
    logic   done_reg, done_next;
    logic   load;
    logic   drain_busy;
    entry_t pass_w [NEAREST_COUNT];
    entry_t held_w [NEAREST_COUNT];
    logic   lt_w   [NEAREST_COUNT];

    assign en   = !(done_reg && drain_busy);
    assign load = done_reg && !drain_busy;

    ngls_dist u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .query_valid (query_valid),
        .query_ready (query_ready),
        .query       (query),
        .cand        (cand)
    );

    genvar i;
    generate
        for (i = 0; i < NEAREST_COUNT; i++)
        begin : g_chain
            if (i == 0)
            begin : g_head
                ngls_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (en),
                    .cand      (cand),
                    .prev_pass ('0),
                    .prev_lt   (1'b0),
                    .pass      (pass_w[i]),
                    .lt        (lt_w[i]),
                    .held      (held_w[i])
                );
            end
            else
            begin : g_body
                ngls_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (en),
                    .cand      (cand),
                    .prev_pass (pass_w[i-1]),
                    .prev_lt   (lt_w[i-1]),
                    .pass      (pass_w[i]),
                    .lt        (lt_w[i]),
                    .held      (held_w[i])
                );
            end
        end
    endgenerate

    always_comb
    begin
        done_next = done_reg;
        if (load)
        begin
            done_next = 1'b0;
        end
        if (en && cand.valid && cand.last)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    ngls_drain u_drain (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .held         (held_w),
        .busy         (drain_busy),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* sv/ngls_checker.sv */
// Port-level checker for the nearest grid lights selection core, with its bind.
// Watches the result channel for ordering, ranking and hold behavior.
// Depends on ngls_pkg and nearest_grid_lights_select_core.
module ngls_checker
    import ngls_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("Result beat changed while stalled.");

    a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last |=>
            result_valid && (result.rank == $past(result.rank) + 1'b1))
        else $error("Rank did not advance by one within a query.");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last |=>
            result.dist_squared >= $past(result.dist_squared))
        else $error("Results are not nearest first.");

    a_final_rank: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.rank == RANK_W'(NEAREST_COUNT - 1)) |-> result.last)
        else $error("Final rank beat is not marked last.");

endmodule

bind nearest_grid_lights_select_core ngls_checker u_ngls_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
